[rtl/l2c_pkg.sv]
// Package for the LBA to CHS converter: geometry, token and slot types,
// register indexes and fixed widths. Depends on nothing else.
`default_nettype none

package l2c_pkg;

    localparam int ADDRESS_WIDTH_DEF = 32;

    localparam int HEADS_W   = 8;
    localparam int SECTORS_W = 6;
    localparam int HS_W      = HEADS_W + SECTORS_W;
    localparam int CYL_W     = 10;
    localparam int LIMIT_W   = HS_W + CYL_W;
    localparam int REM_W     = LIMIT_W;
    localparam int BYTE_W    = 8;
    localparam int NCELLS    = CYL_W + HEADS_W;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_HEADS   = t_cfg_index'(0);
    localparam t_cfg_index REG_SECTORS = t_cfg_index'(1);

    localparam logic [HEADS_W-1:0]   HEADS_RESET   = 8'hff;
    localparam logic [SECTORS_W-1:0] SECTORS_RESET = 6'h3f;
    localparam logic [CYL_W-1:0]     CYL_LIMIT     = 10'h3ff;

    localparam int HS_RESET_INT    = 255 * 63;
    localparam int LIMIT_RESET_INT = 1023 * HS_RESET_INT;

    localparam logic [HS_W-1:0]    HS_RESET    = HS_W'(HS_RESET_INT);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(LIMIT_RESET_INT);

    typedef struct packed {
        logic [HEADS_W-1:0]   heads;
        logic [SECTORS_W-1:0] sectors;
        logic [HS_W-1:0]      hs;
        logic [LIMIT_W-1:0]   limit;
    } t_geom;

    typedef struct packed {
        logic                 sat;
        logic [REM_W-1:0]     rem;
        logic [CYL_W-1:0]     cyl;
        logic [HEADS_W-1:0]   head;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_slot;

endpackage

`default_nettype wire

[rtl/l2c_if.sv]
// Channel interfaces of the LBA to CHS converter: address input, CHS output
// and configuration write. Depends on l2c_pkg.
`default_nettype none

interface l2c_in_if #(
    parameter int ADDRESS_WIDTH = l2c_pkg::ADDRESS_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [ADDRESS_WIDTH-1:0] block_address;

    modport source (output valid, output block_address, input ready);
    modport sink   (input valid, input block_address, output ready);
endinterface

interface l2c_out_if;
    logic                          valid;
    logic                          ready;
    logic [l2c_pkg::BYTE_W-1:0]    head_byte;
    logic [l2c_pkg::BYTE_W-1:0]    sector_byte;
    logic [l2c_pkg::BYTE_W-1:0]    cylinder_low_byte;

    modport source (output valid, output head_byte, output sector_byte,
                    output cylinder_low_byte, input ready);
    modport sink   (input valid, input head_byte, input sector_byte,
                    input cylinder_low_byte, output ready);
endinterface

interface l2c_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [l2c_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [l2c_pkg::CFG_DATA_W-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

[rtl/l2c_cfg.sv]
// Geometry registers of the LBA to CHS converter, with the derived
// heads-times-sectors product and saturation limit. Depends on l2c_pkg, l2c_if.
`default_nettype none

module l2c_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    l2c_cfg_if.sink             i_cfg,
    output l2c_pkg::t_geom      o_geom
);

    localparam int HW = l2c_pkg::HS_W;
    localparam int LW = l2c_pkg::LIMIT_W;
    localparam int CW = l2c_pkg::CYL_W;

    logic [l2c_pkg::HEADS_W-1:0]   r_heads, n_heads;
    logic [l2c_pkg::SECTORS_W-1:0] r_sectors, n_sectors;
    logic [HW-1:0]                 r_hs, n_hs;
    logic [LW-1:0]                 r_limit, n_limit;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_heads   = r_heads;
        n_sectors = r_sectors;
        n_hs      = r_hs;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                l2c_pkg::REG_HEADS: begin
                    n_heads = i_cfg.wr_data[l2c_pkg::HEADS_W-1:0];
                    n_hs    = HW'(n_heads) * HW'(r_sectors);
                end
                l2c_pkg::REG_SECTORS: begin
                    n_sectors = i_cfg.wr_data[l2c_pkg::SECTORS_W-1:0];
                    n_hs      = HW'(r_heads) * HW'(n_sectors);
                end
                default: begin
                    n_hs = r_hs;
                end
            endcase
        end
        n_limit = {r_hs, {CW{1'b0}}} - LW'(r_hs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads   <= l2c_pkg::HEADS_RESET;
            r_sectors <= l2c_pkg::SECTORS_RESET;
            r_hs      <= l2c_pkg::HS_RESET;
            r_limit   <= l2c_pkg::LIMIT_RESET;
        end else begin
            r_heads   <= n_heads;
            r_sectors <= n_sectors;
            r_hs      <= n_hs;
            r_limit   <= n_limit;
        end
    end

    assign o_geom.heads   = r_heads;
    assign o_geom.sectors = r_sectors;
    assign o_geom.hs      = r_hs;
    assign o_geom.limit   = r_limit;

endmodule

`default_nettype wire

[rtl/l2c_entry.sv]
// Entry stages of the LBA to CHS converter: address register, then the
// saturation compare that starts a token. Depends on l2c_pkg, l2c_if.
`default_nettype none

module l2c_entry #(
    parameter int ADDRESS_WIDTH = l2c_pkg::ADDRESS_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    l2c_in_if.sink              i_blk,
    input  wire l2c_pkg::t_geom i_geom,
    input  wire logic           i_down_free,
    output l2c_pkg::t_slot      o_slot
);

    localparam int LW = l2c_pkg::LIMIT_W;

    logic                     r_v0;
    logic [ADDRESS_WIDTH-1:0] r_lba;
    logic                     r_v1;
    l2c_pkg::t_token          r_tok, n_tok;
    logic                     w_free0;
    logic                     w_free1;

    assign w_free1     = !r_v1 || i_down_free;
    assign w_free0     = !r_v0 || w_free1;
    assign i_blk.ready = w_free0;

    always_comb begin
        n_tok      = '0;
        n_tok.sat  = r_lba >= {{(ADDRESS_WIDTH-LW){1'b0}}, i_geom.limit};
        n_tok.rem  = r_lba[l2c_pkg::REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_free0) begin
                r_v0 <= i_blk.valid;
            end
            if (w_free1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free0 && i_blk.valid) begin
            r_lba <= i_blk.block_address;
        end
        if (w_free1 && r_v0) begin
            r_tok <= n_tok;
        end
    end

    assign o_slot.valid = r_v1;
    assign o_slot.tok   = r_tok;

endmodule

`default_nettype wire

[rtl/l2c_div_cell.sv]
// One cell of the divider chain: tries one shifted divisor against the
// partial remainder and records one quotient bit. Depends on l2c_pkg.
`default_nettype none

module l2c_div_cell #(
    parameter int STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire l2c_pkg::t_geom i_geom,
    input  wire l2c_pkg::t_slot i_slot,
    input  wire logic           i_down_free,
    output l2c_pkg::t_slot      o_slot,
    output logic                o_free
);

    localparam int  RW       = l2c_pkg::REM_W;
    localparam bit  IS_CYL   = (STEP < l2c_pkg::CYL_W);
    localparam int  SHIFT    = IS_CYL ? (l2c_pkg::CYL_W - 1 - STEP)
                                      : (l2c_pkg::NCELLS - 1 - STEP);
    localparam int  CYL_SEL  = IS_CYL ? SHIFT : 0;
    localparam int  HEAD_SEL = IS_CYL ? 0 : SHIFT;

    logic            r_valid;
    l2c_pkg::t_token r_tok, n_tok;
    logic [RW-1:0]   w_div;
    logic [RW-1:0]   w_trial;
    logic            w_ge;

    assign o_free  = !r_valid || i_down_free;
    assign w_div   = (IS_CYL ? RW'(i_geom.hs) : RW'(i_geom.sectors)) << SHIFT;
    assign w_ge    = i_slot.tok.rem >= w_div;
    assign w_trial = i_slot.tok.rem - w_div;

    always_comb begin
        n_tok = i_slot.tok;
        if (w_ge) begin
            n_tok.rem = w_trial;
        end
        if (IS_CYL) begin
            n_tok.cyl[CYL_SEL] = w_ge;
        end else begin
            n_tok.head[HEAD_SEL] = w_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_slot.valid) begin
            r_tok <= n_tok;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.tok   = r_tok;

endmodule

`default_nettype wire

[rtl/l2c_out.sv]
// Output register of the LBA to CHS converter: packs a finished token into
// the three CHS bytes or the saturated form. Depends on l2c_pkg, l2c_if.
`default_nettype none

module l2c_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire l2c_pkg::t_geom i_geom,
    input  wire l2c_pkg::t_slot i_slot,
    output logic                o_free,
    l2c_out_if.source           o_chs
);

    localparam int BW = l2c_pkg::BYTE_W;
    localparam int SW = l2c_pkg::SECTORS_W;

    logic          r_valid;
    logic [BW-1:0] r_head, n_head;
    logic [BW-1:0] r_sector, n_sector;
    logic [BW-1:0] r_cyl_low, n_cyl_low;

    assign o_free = !r_valid || o_chs.ready;

    always_comb begin
        if (i_slot.tok.sat) begin
            n_head    = i_geom.heads - BW'(1);
            n_sector  = {l2c_pkg::CYL_LIMIT[9:8], i_geom.sectors};
            n_cyl_low = l2c_pkg::CYL_LIMIT[7:0];
        end else begin
            n_head    = i_slot.tok.head;
            n_sector  = {i_slot.tok.cyl[9:8], i_slot.tok.rem[SW-1:0] + SW'(1)};
            n_cyl_low = i_slot.tok.cyl[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_slot.valid) begin
            r_head    <= n_head;
            r_sector  <= n_sector;
            r_cyl_low <= n_cyl_low;
        end
    end

    assign o_chs.valid             = r_valid;
    assign o_chs.head_byte         = r_head;
    assign o_chs.sector_byte       = r_sector;
    assign o_chs.cylinder_low_byte = r_cyl_low;

endmodule

`default_nettype wire

[rtl/lba_to_chs_converter.sv]
// LBA to CHS converter, top level. One address is accepted per cycle unless
// back-pressure from the output holds the chain. The pipeline is made of two
// entry stages, the chain of 18 divider cells, one quotient bit each, and the
// output register.
// Synchronous reset clears every valid bit and sets the geometry to 255 heads
// and 63 sectors; there is no clearing pass.
// Depends on l2c_pkg, l2c_if, l2c_cfg, l2c_entry, l2c_div_cell and l2c_out.
`default_nettype none

module lba_to_chs_converter #(
    parameter int ADDRESS_WIDTH = l2c_pkg::ADDRESS_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    l2c_in_if.sink     i_blk,
    l2c_cfg_if.sink    i_cfg,
    l2c_out_if.source  o_chs
);

    localparam int NCELLS = l2c_pkg::NCELLS;

    l2c_pkg::t_geom w_geom;
    l2c_pkg::t_slot w_slot [0:NCELLS];
    logic           w_free [0:NCELLS];

    l2c_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_geom  (w_geom)
    );

    l2c_entry #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_entry (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (i_blk),
        .i_geom      (w_geom),
        .i_down_free (w_free[0]),
        .o_slot      (w_slot[0])
    );

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        l2c_div_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_geom      (w_geom),
            .i_slot      (w_slot[g]),
            .i_down_free (w_free[g+1]),
            .o_slot      (w_slot[g+1]),
            .o_free      (w_free[g])
        );
    end

    l2c_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_slot  (w_slot[NCELLS]),
        .o_free  (w_free[NCELLS]),
        .o_chs   (o_chs)
    );

    // An empty output register frees the whole chain, so the input is ready.
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_chs.valid |-> i_blk.ready)
        else $error("input stalled while the output register is empty");

    // The output register loads only from a valid last cell.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_chs.valid && !w_slot[NCELLS].valid) |=> !o_chs.valid)
        else $error("result appeared without a transaction in the last cell");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_chs.valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
